// File: src/vme_pkg.sv
// vme_pkg: shared widths, types and a helper function for the von Mises block
// no dependencies
`timescale 1ns / 1ps

package vme_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int DIFF_W  = DATA_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_W    = 2 * DATA_W + 1;
    localparam int N_W     = 2 * DATA_W + 4;
    localparam int ROOT_W  = DATA_W + 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int TRACE_W = DATA_W + 2;
    localparam int NUM_ENTRIES = 9;
    localparam int IN_DATA_W   = NUM_ENTRIES * DATA_W;
    localparam int OUT_BITS    = DATA_W + TRACE_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // one root bit per stage
    localparam int SQ_STAGES = ROOT_W;

    // divide by three through a reciprocal
    localparam int RECIP_SH = ROOT_W + 2;
    localparam int RECIP_W  = ROOT_W + 1;
    localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / 64'd3;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int DIVP_W = ROOT_W + RECIP_W;

    // queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // tensor kinds
    typedef enum logic [1:0] {
        KIND_STRESS  = 2'd0,
        KIND_STRAIN  = 2'd1,
        KIND_GENERIC = 2'd2,
        KIND_NONE    = 2'd3
    } vme_kind_t;

    // item handed from front to back
    typedef struct packed {
        logic [N_W-1:0]            n;
        logic signed [TRACE_W-1:0] trace;
        logic                      err;
        logic                      strain;
    } vme_item_t;

    // square root stage contents
    typedef struct packed {
        logic [N_W-1:0]            n;
        logic [REM_W-1:0]          rem;
        logic [ROOT_W-1:0]         root;
        logic signed [TRACE_W-1:0] trace;
        logic                      err;
        logic                      strain;
    } vme_sq_t;

    // one restoring square root step: two radicand bits in, one root bit out
    function automatic vme_sq_t sqrt_step(vme_sq_t s);
        vme_sq_t          r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        r      = s;
        rem_sh = {s.rem[REM_W-3:0], s.n[N_W-1:N_W-2]};
        trial  = {1'b0, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        r.n = {s.n[N_W-3:0], 2'b00};
        return r;
    endfunction

endpackage

// File: src/vme_front.sv
// vme_front: accepts tensors, classifies the kind, forms the squared-norm radicand
// depends on vme_pkg
`timescale 1ns / 1ps

module vme_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [vme_pkg::IN_DATA_W-1:0]       in_data,
    input  logic [1:0]                          in_kind,
    output logic                                push,
    input  logic                                q_full,
    output vme_pkg::vme_item_t                  item
);

    localparam int DW = vme_pkg::DATA_W;

    logic                                    en;
    logic signed [DW-1:0]                    e [vme_pkg::NUM_ENTRIES];
    logic                                    is_none;
    logic signed [vme_pkg::DIFF_W-1:0]       diff_next [6];
    logic signed [vme_pkg::TRACE_W-1:0]      trace_next;

    logic                                    v1_reg, v2_reg, v3_reg;
    logic signed [vme_pkg::DIFF_W-1:0]       diff_reg [6];
    logic signed [vme_pkg::TRACE_W-1:0]      tr1_reg, tr2_reg;
    logic                                    err1_reg, err2_reg, str1_reg, str2_reg;
    logic [vme_pkg::SQ_W-1:0]                sq_reg [6];
    logic [vme_pkg::SQ_W-1:0]                sq_next [6];
    logic [vme_pkg::PROD_W-1:0]              prod [6];
    vme_pkg::vme_item_t                      item_reg, item_next;
    logic [vme_pkg::N_W-1:0]                 p_sum, q_sum;

    // signed square at full product width
    function automatic logic [vme_pkg::PROD_W-1:0] PROD_W_CAST(
        logic signed [vme_pkg::DIFF_W-1:0] x);
        logic signed [vme_pkg::PROD_W-1:0] p;
        p = x * x;
        return p;
    endfunction

    // the whole front moves together unless its last stage is blocked
    assign en       = !v3_reg || !q_full;
    assign in_ready = en;
    assign push     = v3_reg && !q_full;
    assign item     = item_reg;

    // entry slicing, differences, shear sums and trace, zeroed for the none kind
    always_comb
    begin
        for (int i = 0; i < vme_pkg::NUM_ENTRIES; i++)
        begin
            e[i] = $signed(in_data[i*DW +: DW]);
        end
        is_none      = (vme_pkg::vme_kind_t'(in_kind) == vme_pkg::KIND_NONE);
        diff_next[0] = vme_pkg::DIFF_W'(e[0]) - vme_pkg::DIFF_W'(e[4]);
        diff_next[1] = vme_pkg::DIFF_W'(e[4]) - vme_pkg::DIFF_W'(e[8]);
        diff_next[2] = vme_pkg::DIFF_W'(e[8]) - vme_pkg::DIFF_W'(e[0]);
        diff_next[3] = vme_pkg::DIFF_W'(e[1]) + vme_pkg::DIFF_W'(e[3]);
        diff_next[4] = vme_pkg::DIFF_W'(e[2]) + vme_pkg::DIFF_W'(e[6]);
        diff_next[5] = vme_pkg::DIFF_W'(e[5]) + vme_pkg::DIFF_W'(e[7]);
        trace_next   = vme_pkg::TRACE_W'(e[0]) + vme_pkg::TRACE_W'(e[4])
                     + vme_pkg::TRACE_W'(e[8]);
        if (is_none)
        begin
            for (int i = 0; i < 6; i++)
            begin
                diff_next[i] = '0;
            end
            trace_next = '0;
        end
    end

    // squares
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            prod[i]    = PROD_W_CAST(diff_reg[i]);
            sq_next[i] = prod[i][vme_pkg::SQ_W-1:0];
        end
    end

    // radicand n = 2p + 3q
    always_comb
    begin
        p_sum = vme_pkg::N_W'(sq_reg[0]) + vme_pkg::N_W'(sq_reg[1])
              + vme_pkg::N_W'(sq_reg[2]);
        q_sum = vme_pkg::N_W'(sq_reg[3]) + vme_pkg::N_W'(sq_reg[4])
              + vme_pkg::N_W'(sq_reg[5]);
        item_next.n      = (p_sum << 1) + (q_sum << 1) + q_sum;
        item_next.trace  = tr2_reg;
        item_next.err    = err2_reg;
        item_next.strain = str2_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                diff_reg[i] <= diff_next[i];
                sq_reg[i]   <= sq_next[i];
            end
            tr1_reg  <= trace_next;
            err1_reg <= is_none;
            str1_reg <= (vme_pkg::vme_kind_t'(in_kind) == vme_pkg::KIND_STRAIN);
            tr2_reg  <= tr1_reg;
            err2_reg <= err1_reg;
            str2_reg <= str1_reg;
            item_reg <= item_next;
        end
    end

endmodule

// File: src/vme_queue.sv
// vme_queue: short queue between front and back
// depends on vme_pkg
`timescale 1ns / 1ps

module vme_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vme_pkg::vme_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output vme_pkg::vme_item_t rd_item
);

    vme_pkg::vme_item_t            mem_reg [vme_pkg::Q_DEPTH];
    logic [vme_pkg::Q_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [vme_pkg::Q_AW:0]        count_reg;

    assign full    = (count_reg == (vme_pkg::Q_AW + 1)'(vme_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: src/vme_back.sv
// vme_back: pipelined square root, scaling by 1/2 or 1/3, saturation, output register
// depends on vme_pkg
`timescale 1ns / 1ps

module vme_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    output logic                              pop,
    input  vme_pkg::vme_item_t                item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vme_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_err
);

    localparam int RW = vme_pkg::ROOT_W;

    logic                      en;
    vme_pkg::vme_sq_t          start;
    vme_pkg::vme_sq_t          sq_reg  [vme_pkg::SQ_STAGES];
    vme_pkg::vme_sq_t          sq_next [vme_pkg::SQ_STAGES];
    logic                      sv_reg  [vme_pkg::SQ_STAGES];

    logic                               dv_reg;
    logic [vme_pkg::DIVP_W-1:0]         prod_reg;
    logic [RW-1:0]                      root_reg;
    logic signed [vme_pkg::TRACE_W-1:0] dtr_reg;
    logic                               derr_reg, dstr_reg;

    logic                               ov_reg;
    logic [vme_pkg::OUT_DATA_W-1:0]     odata_reg;
    logic                               oerr_reg;

    logic [RW-1:0]                      q_est, half, quot;
    logic [RW+1:0]                      rem3;
    logic [vme_pkg::DATA_W-1:0]         eq;
    logic [vme_pkg::OUT_DATA_W-1:0]     odata_next;
    vme_pkg::vme_sq_t                   last;

    // whole back advances when the output register is free or taken
    assign en        = !ov_reg || out_ready;
    assign pop       = en && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = odata_reg;
    assign out_err   = oerr_reg;

    // square root stages
    always_comb
    begin
        start.n      = item.n;
        start.rem    = '0;
        start.root   = '0;
        start.trace  = item.trace;
        start.err    = item.err;
        start.strain = item.strain;
        for (int j = 0; j < vme_pkg::SQ_STAGES; j++)
        begin
            sq_next[j] = vme_pkg::sqrt_step((j == 0) ? start : sq_reg[(j == 0) ? 0 : j - 1]);
        end
        last = sq_reg[vme_pkg::SQ_STAGES-1];
    end

    // divide by three correction, halving, saturation
    always_comb
    begin
        q_est = prod_reg[vme_pkg::RECIP_SH +: RW];
        rem3  = (RW + 2)'(root_reg) - ((RW + 2)'(q_est) << 1) - (RW + 2)'(q_est);
        quot  = (rem3 >= (RW + 2)'(3)) ? q_est + 1'b1 : q_est;
        half  = root_reg >> 1;
        if (dstr_reg)
        begin
            if (|quot[RW-1:vme_pkg::DATA_W])
            begin
                eq = '1;
            end
            else
            begin
                eq = quot[vme_pkg::DATA_W-1:0];
            end
        end
        else if (|half[RW-1:vme_pkg::DATA_W])
        begin
            eq = '1;
        end
        else
        begin
            eq = half[vme_pkg::DATA_W-1:0];
        end
        odata_next = vme_pkg::OUT_DATA_W'({dtr_reg, eq});
        if (derr_reg)
        begin
            odata_next = '0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < vme_pkg::SQ_STAGES; j++)
            begin
                sv_reg[j] <= 1'b0;
            end
            dv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= !q_empty;
            for (int j = 1; j < vme_pkg::SQ_STAGES; j++)
            begin
                sv_reg[j] <= sv_reg[j-1];
            end
            dv_reg <= sv_reg[vme_pkg::SQ_STAGES-1];
            ov_reg <= dv_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < vme_pkg::SQ_STAGES; j++)
            begin
                sq_reg[j] <= sq_next[j];
            end
            prod_reg  <= last.root * vme_pkg::RECIP;
            root_reg  <= last.root;
            dtr_reg   <= last.trace;
            derr_reg  <= last.err;
            dstr_reg  <= last.strain;
            odata_reg <= odata_next;
            oerr_reg  <= derr_reg;
        end
    end

endmodule

// File: src/von_mises_equivalent.sv
// von_mises_equivalent: top level, front end, queue and root/scale back end
// depends on vme_pkg, vme_front, vme_queue, vme_back
`timescale 1ns / 1ps
//
//  channel  direction  tdata                                   tuser
//  s_       in         m_xx..m_zz, 32 bits each, m_xx lowest   command [1:0]
//  m_       out        equivalent [31:0], trace_sum [65:32]    kind_error
//
//  one tensor per cycle sustained while m_tready stays high; the path runs through three
//  front stages, the queue, one square root stage per result bit (34), a multiply
//  stage for the divide by three and the output register
//  the front and back stall independently; the four-entry queue absorbs the
//  difference, and s_tready drops only when the queue is full
//  reset clears valid flags, queue pointers and fill count only

module von_mises_equivalent (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [vme_pkg::IN_DATA_W-1:0]      s_tdata,   // m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz
    input  logic [1:0]                         s_tuser,   // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vme_pkg::OUT_DATA_W-1:0]     m_tdata,   // equivalent, trace_sum, zero pad
    output logic                               m_tuser    // kind_error
);

    logic               push, full, pop, empty;
    vme_pkg::vme_item_t f_item, q_item;

    // front end
    vme_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_kind  (s_tuser),
        .push     (push),
        .q_full   (full),
        .item     (f_item)
    );

    // queue
    vme_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (f_item),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .rd_item (q_item)
    );

    // back end
    vme_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .pop       (pop),
        .item      (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_err   (m_tuser)
    );

endmodule

// File: src/vme_checker.sv
// vme_checker: port-level assertions for von_mises_equivalent, bound to the top level
// depends on vme_pkg, von_mises_equivalent
`timescale 1ns / 1ps

module vme_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vme_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // an error result carries zero value and trace
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("kind error result with nonzero payload");

    // pad bits above the trace stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[vme_pkg::OUT_DATA_W-1:vme_pkg::OUT_BITS] == '0)
        else $error("output pad bits set");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind von_mises_equivalent vme_checker u_vme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
